// File: hw/rtl/lsct_pkg.sv
// Package for the line sensor centroid tracker: sizes, register indexes, codes.
// No dependencies.
`default_nettype none
package lsct_pkg;
    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int ERR_W           = 13;
    localparam int SUM_W           = 13;
    localparam int STATE_W         = 3;
    localparam int CMD_W           = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALIB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic [STATE_W-1:0] LS_STRONG  = 3'd0;
    localparam logic [STATE_W-1:0] LS_WEAK    = 3'd1;
    localparam logic [STATE_W-1:0] LS_SLOW    = 3'd2;
    localparam logic [STATE_W-1:0] LS_FAST    = 3'd3;
    localparam logic [STATE_W-1:0] LS_STOPPED = 3'd4;
    localparam logic [STATE_W-1:0] LS_CALIB   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_STRONG = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEAK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOPT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FASTV  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 3'd6;
endpackage
`default_nettype wire

// File: hw/rtl/line_sensor_centroid_tracker.sv
// Line sensor centroid tracker top level: calibration store, shared divider, sequencer.
// Depends on lsct_pkg.
`default_nettype none
// One item at a time. Clear, calibrate and unused commands step through the channels
// one channel per cycle, then take a quality count over the channels. Compute uses one
// restoring divider, 26 bits wide for the default sizes, that serves every per-channel
// scale division and the final centroid division in turn, then the same quality pass.
// The input is not ready until the result beat has been taken.
module line_sensor_centroid_tracker #(
    parameter int CHANNELS    = lsct_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = lsct_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // samples, channel 0 lowest, zero padded to bytes
    input  wire  [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  wire  [lsct_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // position_error[12:0], line_state[15:13], line_sum[28:16], calib_good[29]
    output logic [31:0]                         m_axis_tdata,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [lsct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [lsct_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lsct_pkg::*;

    localparam int CH_W   = $clog2(CHANNELS);
    localparam int CHC_W  = $clog2(CHANNELS + 1);
    localparam int SMAX   = (1 << SAMPLE_BITS) - 1;
    localparam int SC_W   = 10;                     // scaled value 0..1000
    localparam int VS_W   = $clog2(CHANNELS*1000 + 1);
    localparam int WS_W   = $clog2((CHANNELS-1)*1000*1000*CHANNELS + 1);
    localparam int NUM_W  = (WS_W > SAMPLE_BITS + 10) ? WS_W : SAMPLE_BITS + 10;
    localparam int DEN_W  = (VS_W > SAMPLE_BITS) ? VS_W : SAMPLE_BITS;
    localparam int IT_W   = $clog2(NUM_W + 1);
    localparam int CENTRE = ((CHANNELS - 1) * 1000) / 2;
    localparam int DW     = ((CHANNELS*SAMPLE_BITS+7)/8)*8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CAL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_CDIV = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_QUAL = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // configuration registers
    logic [12:0] r_strong, r_weak;
    logic [15:0] r_slowt, r_stopt;
    logic [11:0] r_slowv, r_fastv, r_span;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strong <= 13'd1200; r_weak <= 13'd800;
            r_slowt <= 16'd100; r_stopt <= 16'd500;
            r_slowv <= 12'd1500; r_fastv <= 12'd1800; r_span <= 12'd500;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STRONG: r_strong <= i_cfg_data[12:0];
                REG_WEAK:   r_weak   <= i_cfg_data[12:0];
                REG_SLOWT:  r_slowt  <= i_cfg_data;
                REG_STOPT:  r_stopt  <= i_cfg_data;
                REG_SLOWV:  r_slowv  <= i_cfg_data[11:0];
                REG_FASTV:  r_fastv  <= i_cfg_data[11:0];
                REG_SPAN:   r_span   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // state
    logic [2:0]              r_st;
    logic [CMD_W-1:0]        r_cmd;
    logic [DW-1:0]           r_smp;
    logic [CHC_W-1:0]        r_ch;
    logic [SAMPLE_BITS-1:0]  r_min [CHANNELS];
    logic [SAMPLE_BITS-1:0]  r_max [CHANNELS];
    logic [ERR_W-1:0]        r_last;
    logic [15:0]             r_lost;
    logic [VS_W-1:0]         r_vsum;
    logic [WS_W-1:0]         r_wsum;
    logic [NUM_W-1:0]        r_q;      // dividend shifting into quotient
    logic [DEN_W:0]          r_rem;
    logic [DEN_W-1:0]        r_den;
    logic [IT_W-1:0]         r_it;
    logic [CHC_W-1:0]        r_good;
    logic [ERR_W-1:0]        r_err;
    logic [STATE_W-1:0]      r_ls;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_cg;

    // current channel's operands
    logic [CH_W-1:0]         ch;
    logic [SAMPLE_BITS-1:0]  smp, mn, mx;
    assign ch  = r_ch[CH_W-1:0];
    assign smp = r_smp[ch*SAMPLE_BITS +: SAMPLE_BITS];
    assign mn  = r_min[ch];
    assign mx  = r_max[ch];

    // shared restoring divider step
    logic [DEN_W:0] trial;
    logic           fits;
    assign trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    logic [NUM_W-1:0] qv;
    assign qv = {r_q[NUM_W-2:0], fits};

    // centroid finish
    logic signed [WS_W+1:0] e_full;
    logic signed [ERR_W-1:0] e_sat;
    logic signed [ERR_W+3:0] e7;
    logic [ERR_W+1:0]        e7_mag;   // |error*7| stays below 2^15
    logic [31:0]             e7_rcp;
    logic signed [ERR_W-1:0] e_weak;
    logic [15:0] lost_n;
    assign e_full = $signed({2'b00, r_q[WS_W-1:0]}) - (WS_W+2)'(CENTRE);
    assign e_sat  = (e_full > 4095) ? 13'sd4095 :
                    (e_full < -4096) ? $signed(13'h1000) : e_full[ERR_W-1:0];
    assign e7     = 17'(e_sat) * 17'sd7;
    // divide by ten via 2^19/10 reciprocal, exact for this range, sign restored after
    assign e7_mag = e7[ERR_W+3] ? (ERR_W+2)'(-e7) : (ERR_W+2)'(e7);
    assign e7_rcp = 32'(e7_mag) * 32'd52429;
    assign e_weak = e7[ERR_W+3] ? -e7_rcp[31:19] : e7_rcp[31:19];
    assign lost_n = (r_lost == 16'hFFFF) ? r_lost : r_lost + 16'd1;

    logic [SC_W+SAMPLE_BITS-1:0] v_clamp;
    assign v_clamp = (r_q > NUM_W'(1000)) ? (SC_W+SAMPLE_BITS)'(1000)
                                          : (SC_W+SAMPLE_BITS)'(r_q);

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata  = {2'b00, r_cg, r_sum, r_ls, r_err};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_last <= '0; r_lost <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_min[i] <= SAMPLE_BITS'(SMAX); r_max[i] <= '0;
            end
        end else begin
            case (r_st)
                S_IDLE: if (s_axis_tvalid) begin
                    r_cmd <= s_axis_tuser; r_smp <= s_axis_tdata; r_ch <= '0;
                    r_vsum <= '0; r_wsum <= '0;
                    r_err <= '0; r_ls <= LS_CALIB; r_sum <= '0;
                    r_st <= (s_axis_tuser == CMD_COMP) ? S_DIV : S_CAL;
                    r_it <= '0;
                end
                S_CAL: begin
                    if (r_cmd == CMD_CLEAR) begin
                        r_min[ch] <= SAMPLE_BITS'(SMAX); r_max[ch] <= '0;
                    end else if (r_cmd == CMD_CALIB) begin
                        if (smp < mn) r_min[ch] <= smp;
                        if (smp > mx) r_max[ch] <= smp;
                    end
                    if (r_ch == CHC_W'(CHANNELS-1)) begin
                        r_st <= S_QUAL; r_ch <= '0; r_good <= '0;
                    end else r_ch <= r_ch + 1'b1;
                end
                S_DIV: begin
                    if (r_it == '0) begin
                        // load: (s-min)*1000 / range
                        r_q   <= NUM_W'((smp > mn) ? (smp - mn) : '0) * NUM_W'(1000);
                        r_den <= DEN_W'((mx > mn) ? (mx - mn) : SAMPLE_BITS'(1));
                        r_rem <= '0; r_it <= r_it + 1'b1;
                    end else begin
                        r_rem <= fits ? trial - {1'b0, r_den} : trial;
                        r_q   <= qv;
                        if (r_it == IT_W'(NUM_W)) r_st <= S_ACC;
                        r_it <= r_it + 1'b1;
                    end
                end
                S_ACC: begin
                    r_vsum <= r_vsum + VS_W'(v_clamp);
                    r_wsum <= r_wsum + WS_W'(v_clamp[SC_W-1:0]) * WS_W'(ch * 1000);
                    r_it <= '0;
                    if (r_ch == CHC_W'(CHANNELS-1)) r_st <= S_CDIV;
                    else begin
                        r_ch <= r_ch + 1'b1; r_st <= S_DIV;
                    end
                end
                S_CDIV: begin
                    if (r_it == '0) begin
                        r_q <= NUM_W'(r_wsum);
                        r_den <= (r_vsum == '0) ? DEN_W'(1) : DEN_W'(r_vsum);
                        r_rem <= '0; r_it <= r_it + 1'b1;
                    end else begin
                        r_rem <= fits ? trial - {1'b0, r_den} : trial;
                        r_q   <= qv;
                        if (r_it == IT_W'(NUM_W)) r_st <= S_FIN;
                        r_it <= r_it + 1'b1;
                    end
                end
                S_FIN: begin
                    r_sum <= (r_vsum > VS_W'(8191)) ? 13'd8191 : SUM_W'(r_vsum);
                    if (r_vsum > VS_W'(r_strong) || r_vsum > VS_W'(r_weak)) begin
                        r_lost <= '0; r_last <= e_sat;
                        if (r_vsum > VS_W'(r_strong)) begin
                            r_err <= e_sat; r_ls <= LS_STRONG;
                        end else begin
                            r_err <= e_weak; r_ls <= LS_WEAK;
                        end
                    end else begin
                        r_lost <= lost_n;
                        if (lost_n < r_slowt) begin
                            r_err <= r_last[ERR_W-1] ? -{1'b0, r_slowv} : {1'b0, r_slowv};
                            r_ls <= LS_SLOW;
                        end else if (lost_n < r_stopt) begin
                            r_err <= r_last[ERR_W-1] ? -{1'b0, r_fastv} : {1'b0, r_fastv};
                            r_ls <= LS_FAST;
                        end else begin
                            r_err <= '0; r_ls <= LS_STOPPED;
                        end
                    end
                    r_st <= S_QUAL; r_ch <= '0; r_good <= '0;
                end
                S_QUAL: begin
                    if (mx > mn && (mx - mn) > r_span) r_good <= r_good + 1'b1;
                    if (r_ch == CHC_W'(CHANNELS-1)) begin
                        r_cg <= ((mx > mn && (mx - mn) > r_span) ? r_good + 1'b1 : r_good)
                                >= CHC_W'(CHANNELS-2);
                        r_st <= S_OUT;
                    end else r_ch <= r_ch + 1'b1;
                end
                S_OUT: if (m_axis_tready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result held");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_calib_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_ls == LS_CALIB |-> r_err == '0 && r_sum == '0)
        else $error("calibration result not zero");
`endif
endmodule
`default_nettype wire
